[rtl/gdec_pkg.sv]
`timescale 1ns / 1ps

package gdec_pkg;

  localparam logic       LAYOUT_GEN5 = 1'b0;
  localparam logic       LAYOUT_GEN4 = 1'b1;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BAD_ID = 2'd1;
  localparam logic [1:0] STATUS_SHORT  = 2'd2;

  localparam logic [2:0] BATT_EMPTY   = 3'd0;
  localparam logic [2:0] BATT_LOW     = 3'd1;
  localparam logic [2:0] BATT_MEDIUM  = 3'd2;
  localparam logic [2:0] BATT_FULL    = 3'd3;
  localparam logic [2:0] BATT_UNAVAIL = 3'd4;

  localparam logic [7:0] ID_COMMON = 8'h01;
  localparam logic [7:0] ID_GEN5   = 8'h31;
  localparam logic [7:0] ID_GEN4   = 8'h11;

  localparam logic [1:0] BASE_COMMON = 2'd1;
  localparam logic [1:0] BASE_GEN5   = 2'd2;
  localparam logic [1:0] BASE_GEN4   = 2'd3;

  localparam logic [7:0] MIN_LEN_GEN5  = 8'd12;
  localparam logic [7:0] MIN_LEN_GEN4  = 8'd10;
  localparam logic [7:0] LAST_REL_GEN5 = 8'd9;
  localparam logic [7:0] LAST_REL_GEN4 = 8'd8;
  localparam logic [7:0] BATT_REL_GEN5 = 8'd52;
  localparam logic [7:0] BATT_REL_GEN4 = 8'd29;

  localparam logic [15:0] BTN_UP     = 16'h0001;
  localparam logic [15:0] BTN_DOWN   = 16'h0002;
  localparam logic [15:0] BTN_LEFT   = 16'h0004;
  localparam logic [15:0] BTN_RIGHT  = 16'h0008;
  localparam logic [15:0] BTN_START  = 16'h0010;
  localparam logic [15:0] BTN_BACK   = 16'h0020;
  localparam logic [15:0] BTN_LTHUMB = 16'h0040;
  localparam logic [15:0] BTN_RTHUMB = 16'h0080;
  localparam logic [15:0] BTN_LSH    = 16'h0100;
  localparam logic [15:0] BTN_RSH    = 16'h0200;
  localparam logic [15:0] BTN_A      = 16'h1000;
  localparam logic [15:0] BTN_B      = 16'h2000;
  localparam logic [15:0] BTN_X      = 16'h4000;
  localparam logic [15:0] BTN_Y      = 16'h8000;

  typedef struct packed {
    logic [7:0] report_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        buttons;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [2:0]         battery_class;
    logic               charging;
    logic [31:0]        packet_number;
  } out_res_t;

  typedef struct packed {
    logic            done;
    logic [7:0]      len;
    logic [1:0]      base;
    logic            id_valid;
    logic [7:0][7:0] fields;
    logic [7:0]      battery;
  } gdec_frame_t;

  function automatic logic [15:0] hat_bits(input logic [3:0] hat);
    logic [15:0] w;
    begin
      case (hat)
        4'd0:    w = BTN_UP;
        4'd1:    w = BTN_UP | BTN_RIGHT;
        4'd2:    w = BTN_RIGHT;
        4'd3:    w = BTN_RIGHT | BTN_DOWN;
        4'd4:    w = BTN_DOWN;
        4'd5:    w = BTN_DOWN | BTN_LEFT;
        4'd6:    w = BTN_LEFT;
        4'd7:    w = BTN_LEFT | BTN_UP;
        default: w = 16'h0000;
      endcase
      return w;
    end
  endfunction

  function automatic logic [15:0] pack_buttons(input logic [7:0] b1, input logic [7:0] b2);
    logic [15:0] w;
    begin
      w = hat_bits(b1[3:0]);
      if (b1[4]) w = w | BTN_X;
      if (b1[5]) w = w | BTN_A;
      if (b1[6]) w = w | BTN_B;
      if (b1[7]) w = w | BTN_Y;
      if (b2[0]) w = w | BTN_LSH;
      if (b2[1]) w = w | BTN_RSH;
      if (b2[4]) w = w | BTN_BACK;
      if (b2[5]) w = w | BTN_START;
      if (b2[6]) w = w | BTN_LTHUMB;
      if (b2[7]) w = w | BTN_RTHUMB;
      return w;
    end
  endfunction

  function automatic logic [2:0] battery_class_of(input logic [7:0] level_in);
    logic [7:0] level;
    logic [2:0] cls;
    begin
      level = level_in;
      if (level > 8'd10) level = {4'h0, level[3:0]};
      if (level == 8'd0) cls = BATT_EMPTY;
      else if (level <= 8'd2) cls = BATT_LOW;
      else if (level <= 8'd7) cls = BATT_MEDIUM;
      else cls = BATT_FULL;
      return cls;
    end
  endfunction

endpackage

[rtl/gdec_capture.sv]
`timescale 1ns / 1ps

module gdec_capture #(
  parameter int MAX_REPORT_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pad_layout,
  input  logic                 in_fire,
  input  gdec_pkg::in_req_t    in_req,
  output gdec_pkg::gdec_frame_t frame
);

  logic [7:0]      byte_count_r, byte_count_nxt;
  logic [1:0]      base_offset_r, base_offset_nxt;
  logic            id_valid_r, id_valid_nxt;
  logic [7:0][7:0] fields_r, fields_nxt;
  logic [7:0]      battery_r, battery_nxt;
  logic [7:0]      rel;
  logic [7:0]      rel_m1;
  logic [7:0]      batt_rel;
  logic            take;

  assign batt_rel = (pad_layout == gdec_pkg::LAYOUT_GEN4) ? gdec_pkg::BATT_REL_GEN4
                                                          : gdec_pkg::BATT_REL_GEN5;
  assign take   = in_fire && (byte_count_r < 8'(MAX_REPORT_BYTES));
  assign rel    = byte_count_r - {6'd0, base_offset_r};
  assign rel_m1 = rel - 8'd1;

  always_comb begin
    byte_count_nxt  = byte_count_r;
    base_offset_nxt = base_offset_r;
    id_valid_nxt    = id_valid_r;
    fields_nxt      = fields_r;
    battery_nxt     = battery_r;
    if (take) begin
      byte_count_nxt = byte_count_r + 8'd1;
      if (byte_count_r == 8'd0) begin
        id_valid_nxt    = 1'b0;
        base_offset_nxt = 2'd0;
        if (in_req.report_byte == gdec_pkg::ID_COMMON) begin
          id_valid_nxt    = 1'b1;
          base_offset_nxt = gdec_pkg::BASE_COMMON;
        end else if (pad_layout == gdec_pkg::LAYOUT_GEN5 &&
                     in_req.report_byte == gdec_pkg::ID_GEN5) begin
          id_valid_nxt    = 1'b1;
          base_offset_nxt = gdec_pkg::BASE_GEN5;
        end else if (pad_layout == gdec_pkg::LAYOUT_GEN4 &&
                     in_req.report_byte == gdec_pkg::ID_GEN4) begin
          id_valid_nxt    = 1'b1;
          base_offset_nxt = gdec_pkg::BASE_GEN4;
        end
      end else if (id_valid_r && byte_count_r >= {6'd0, base_offset_r}) begin
        if (rel <= 8'd5) begin
          fields_nxt[rel[2:0]] = in_req.report_byte;
        end else if (rel == 8'd7 || rel == 8'd8) begin
          fields_nxt[rel_m1[2:0]] = in_req.report_byte;
        end
        if (rel == batt_rel) begin
          battery_nxt = in_req.report_byte;
        end
      end
    end
  end

  always_comb begin
    frame.done     = in_fire && in_req.last_byte;
    frame.len      = byte_count_nxt;
    frame.base     = base_offset_nxt;
    frame.id_valid = id_valid_nxt;
    frame.fields   = fields_nxt;
    frame.battery  = battery_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= 8'd0;
      base_offset_r <= 2'd0;
      id_valid_r    <= 1'b0;
    end else if (frame.done) begin
      byte_count_r  <= 8'd0;
      base_offset_r <= 2'd0;
      id_valid_r    <= 1'b0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      base_offset_r <= base_offset_nxt;
      id_valid_r    <= id_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fields_r  <= fields_nxt;
    battery_r <= battery_nxt;
  end

endmodule

[rtl/gdec_format.sv]
`timescale 1ns / 1ps

module gdec_format (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pad_layout,
  input  gdec_pkg::gdec_frame_t frame,
  output logic                  out_valid,
  input  logic                  out_stall,
  output gdec_pkg::out_res_t    out_res
);

  logic [31:0]        packet_counter_r, packet_counter_nxt;
  logic               out_valid_r;
  gdec_pkg::out_res_t out_res_r;
  gdec_pkg::out_res_t res;
  logic [7:0]         min_len;
  logic [7:0]         last_data;
  logic [7:0]         batt_lim;
  logic [1:0]         status;
  logic [7:0]         b1, b2, lt, rt;
  logic [7:0]         level;
  logic               gen4;

  assign gen4      = (pad_layout == gdec_pkg::LAYOUT_GEN4);
  assign min_len   = gen4 ? gdec_pkg::MIN_LEN_GEN4 : gdec_pkg::MIN_LEN_GEN5;
  assign last_data = {6'd0, frame.base} +
                     (gen4 ? gdec_pkg::LAST_REL_GEN4 : gdec_pkg::LAST_REL_GEN5);
  assign batt_lim  = {6'd0, frame.base} +
                     (gen4 ? gdec_pkg::BATT_REL_GEN4 : gdec_pkg::BATT_REL_GEN5);
  assign level     = gen4 ? frame.battery : {4'h0, frame.battery[3:0]};

  always_comb begin
    if (frame.len < min_len) status = gdec_pkg::STATUS_SHORT;
    else if (!frame.id_valid) status = gdec_pkg::STATUS_BAD_ID;
    else if (frame.len <= last_data) status = gdec_pkg::STATUS_SHORT;
    else status = gdec_pkg::STATUS_OK;
  end

  always_comb begin
    if (gen4) begin
      b1 = frame.fields[4];
      b2 = frame.fields[5];
      lt = frame.fields[6];
      rt = frame.fields[7];
    end else begin
      lt = frame.fields[4];
      rt = frame.fields[5];
      b1 = frame.fields[6];
      b2 = frame.fields[7];
    end
  end

  always_comb begin
    packet_counter_nxt = packet_counter_r;
    res                = '0;
    res.status         = status;
    res.battery_class  = gdec_pkg::BATT_UNAVAIL;
    if (status == gdec_pkg::STATUS_OK) begin
      packet_counter_nxt = packet_counter_r + 32'd1;
      res.buttons        = gdec_pkg::pack_buttons(b1, b2);
      res.left_trigger   = lt;
      res.right_trigger  = rt;
      res.left_x         = {frame.fields[0] ^ 8'h80, 8'h00};
      res.left_y         = {~frame.fields[1] ^ 8'h80, 8'h00};
      res.right_x        = {frame.fields[2] ^ 8'h80, 8'h00};
      res.right_y        = {~frame.fields[3] ^ 8'h80, 8'h00};
      if (frame.len > batt_lim) begin
        res.battery_class = gdec_pkg::battery_class_of(level);
        res.charging      = frame.battery[4];
      end
    end
    res.packet_number = packet_counter_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r      <= 1'b0;
      packet_counter_r <= 32'd0;
    end else begin
      if (frame.done) begin
        out_valid_r      <= 1'b1;
        packet_counter_r <= packet_counter_nxt;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame.done) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

[rtl/gamepad_report_decoder_top.sv]
`timescale 1ns / 1ps

// Decodes a gamepad input report that arrives one byte per request on the
// input channel, with last_byte set on the final byte of the report.
// Each request carries one byte; a request with last_byte set produces exactly
// one result request on the output channel, and other bytes produce none.
// The result appears on the output register in the cycle after the final byte
// is accepted, and the block takes one byte every cycle while the output side
// keeps up.
// The input is stalled only while a result sits in the output register and
// the receiver stalls it; that single output register sets the throughput.
// The configuration channel writes the report layout (0 or 1), which must be
// changed only while no report is in progress; it is always ready.
// Reset clears the byte count, the layout, the packet counter and the output
// valid, so the first byte after reset is taken as the report id.
// While the receiver stalls, the result and out_valid hold their values.

module gamepad_report_decoder_top #(
  parameter int MAX_REPORT_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gdec_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output gdec_pkg::out_res_t out_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_pad_layout
);

  logic                  pad_layout_r;
  logic                  in_fire;
  gdec_pkg::gdec_frame_t frame;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_layout_r <= gdec_pkg::LAYOUT_GEN5;
    end else if (cfg_valid && cfg_ready) begin
      pad_layout_r <= cfg_pad_layout;
    end
  end

  gdec_capture #(
    .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
  ) u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .pad_layout(pad_layout_r),
    .in_fire   (in_fire),
    .in_req    (in_req),
    .frame     (frame)
  );

  gdec_format u_format (
    .clk       (clk),
    .rst_n     (rst_n),
    .pad_layout(pad_layout_r),
    .frame     (frame),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule

[tb/gamepad_report_checker.sv]
`timescale 1ns / 1ps

module gamepad_report_checker #(
  parameter int MAX_REPORT_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  gdec_pkg::in_req_t  in_req,
  input  logic               out_valid,
  input  logic               out_stall,
  input  gdec_pkg::out_res_t out_res,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_pad_layout,
  output int                 n_fail,
  output int                 n_pending,
  output int                 n_results,
  output int                 n_ok
);

  logic       layout;
  logic [7:0] count;
  logic [1:0] base;
  logic       id_ok;
  logic [7:0] fields [8];
  logic [7:0] batt;
  logic [31:0] decoded;
  gdec_pkg::out_res_t expected_reports[$];

  function automatic logic [15:0] button_word(input logic [7:0] b1, input logic [7:0] b2);
    logic [15:0] w;
    case (b1[3:0])
      4'd0:    w = gdec_pkg::BTN_UP;
      4'd1:    w = gdec_pkg::BTN_UP | gdec_pkg::BTN_RIGHT;
      4'd2:    w = gdec_pkg::BTN_RIGHT;
      4'd3:    w = gdec_pkg::BTN_RIGHT | gdec_pkg::BTN_DOWN;
      4'd4:    w = gdec_pkg::BTN_DOWN;
      4'd5:    w = gdec_pkg::BTN_DOWN | gdec_pkg::BTN_LEFT;
      4'd6:    w = gdec_pkg::BTN_LEFT;
      4'd7:    w = gdec_pkg::BTN_LEFT | gdec_pkg::BTN_UP;
      default: w = '0;
    endcase
    w[15:12] = {b1[7], b1[4], b1[6], b1[5]};
    w[9:8]   = b2[1:0];
    w[7:4]   = {b2[7], b2[6], b2[4], b2[5]};
    return w;
  endfunction

  function automatic logic [2:0] charge_class(input logic [7:0] raw, input logic gen4);
    logic [7:0] lvl;
    lvl = gen4 ? raw : {4'h0, raw[3:0]};
    if (lvl > 8'd10) lvl = {4'h0, lvl[3:0]};
    if (lvl == 8'd0) return gdec_pkg::BATT_EMPTY;
    else if (lvl <= 8'd2) return gdec_pkg::BATT_LOW;
    else if (lvl <= 8'd7) return gdec_pkg::BATT_MEDIUM;
    return gdec_pkg::BATT_FULL;
  endfunction

  function automatic bit field_matches(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int       pos;
    int       rel;
    int       len;
    int       min_len;
    int       last_data;
    int       batt_rel;
    logic     gen4;
    logic [7:0] b1;
    logic [7:0] b2;
    gdec_pkg::out_res_t r;
    gen4 = (layout == gdec_pkg::LAYOUT_GEN4);
    batt_rel = gen4 ? gdec_pkg::BATT_REL_GEN4 : gdec_pkg::BATT_REL_GEN5;
    if (count < MAX_REPORT_BYTES) begin
      pos = count;
      count = count + 8'd1;
      if (pos == 0) begin
        id_ok = 1'b0;
        base = '0;
        if (b == gdec_pkg::ID_COMMON) begin
          id_ok = 1'b1;
          base = gdec_pkg::BASE_COMMON;
        end else if (!gen4 && b == gdec_pkg::ID_GEN5) begin
          id_ok = 1'b1;
          base = gdec_pkg::BASE_GEN5;
        end else if (gen4 && b == gdec_pkg::ID_GEN4) begin
          id_ok = 1'b1;
          base = gdec_pkg::BASE_GEN4;
        end
      end else if (id_ok && pos >= base) begin
        rel = pos - base;
        if (rel <= 5) fields[rel] = b;
        else if (rel == 7 || rel == 8) fields[rel - 1] = b;
        if (rel == batt_rel) batt = b;
      end
    end
    if (last) begin
      len = count;
      min_len = gen4 ? gdec_pkg::MIN_LEN_GEN4 : gdec_pkg::MIN_LEN_GEN5;
      last_data = base + (gen4 ? gdec_pkg::LAST_REL_GEN4 : gdec_pkg::LAST_REL_GEN5);
      r = '0;
      r.battery_class = gdec_pkg::BATT_UNAVAIL;
      r.packet_number = decoded;
      if (len < min_len) begin
        r.status = gdec_pkg::STATUS_SHORT;
      end else if (!id_ok) begin
        r.status = gdec_pkg::STATUS_BAD_ID;
      end else if (len <= last_data) begin
        r.status = gdec_pkg::STATUS_SHORT;
      end else begin
        if (gen4) begin
          b1 = fields[4];
          b2 = fields[5];
          r.left_trigger = fields[6];
          r.right_trigger = fields[7];
        end else begin
          r.left_trigger = fields[4];
          r.right_trigger = fields[5];
          b1 = fields[6];
          b2 = fields[7];
        end
        decoded = decoded + 32'd1;
        n_ok++;
        r.status = gdec_pkg::STATUS_OK;
        r.buttons = button_word(b1, b2);
        r.left_x = {fields[0] ^ 8'h80, 8'h00};
        r.left_y = {fields[1] ^ 8'h7F, 8'h00};
        r.right_x = {fields[2] ^ 8'h80, 8'h00};
        r.right_y = {fields[3] ^ 8'h7F, 8'h00};
        if (len > base + batt_rel) begin
          r.battery_class = charge_class(batt, gen4);
          r.charging = batt[4];
        end
        r.packet_number = decoded;
      end
      expected_reports.push_back(r);
      count = '0;
      base = '0;
      id_ok = 1'b0;
    end
  endtask

  task automatic check_report(input gdec_pkg::out_res_t got);
    gdec_pkg::out_res_t want;
    bit       ok;
    n_results++;
    if (expected_reports.size() == 0) begin
      $error("result request with no report pending, status %0d", got.status);
      n_fail++;
    end else begin
      want = expected_reports.pop_front();
      ok = field_matches("status", want.status, got.status)
         & field_matches("buttons", want.buttons, got.buttons)
         & field_matches("left_trigger", want.left_trigger, got.left_trigger)
         & field_matches("right_trigger", want.right_trigger, got.right_trigger)
         & field_matches("left_x", want.left_x, got.left_x)
         & field_matches("left_y", want.left_y, got.left_y)
         & field_matches("right_x", want.right_x, got.right_x)
         & field_matches("right_y", want.right_y, got.right_y)
         & field_matches("battery_class", want.battery_class, got.battery_class)
         & field_matches("charging", want.charging, got.charging)
         & field_matches("packet_number", want.packet_number, got.packet_number);
      if (!ok) n_fail++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      layout = gdec_pkg::LAYOUT_GEN5;
      count = '0;
      base = '0;
      id_ok = 1'b0;
      batt = '0;
      decoded = '0;
      n_fail = 0;
      n_results = 0;
      n_ok = 0;
      foreach (fields[i]) fields[i] = '0;
      expected_reports.delete();
    end else begin
      if (in_valid && !in_stall) absorb_byte(in_req.report_byte, in_req.last_byte);
      if (out_valid && !out_stall) check_report(out_res);
      if (cfg_valid && cfg_ready) layout = cfg_pad_layout;
    end
    n_pending = expected_reports.size();
  end

endmodule

[tb/tb_gamepad_report_decoder_top.sv]
`timescale 1ns / 1ps

module tb_gamepad_report_decoder_top;

  localparam int REPORT_BYTES = 1650;
  localparam int CALM_BYTES   = 150;
  localparam int PHASE_BYTES  = 140;
  localparam int QUIET_LIMIT  = 2000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  gdec_pkg::in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  gdec_pkg::out_res_t out_res;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_pad_layout = 1'b0;

  int n_fail;
  int n_pending;
  int n_results;
  int n_ok;

  logic [7:0]  report[$];
  logic        cur_layout = gdec_pkg::LAYOUT_GEN5;
  int          sent_bytes = 0;
  int          sent_reports = 0;
  int          layout_writes = 0;
  int          next_phase = 0;
  int unsigned idle_pct = 8;
  bit          calm = 1'b0;
  int          stall_left = 0;
  int          quiet = 0;

  always #4 clk = ~clk;

  gamepad_report_decoder_top #(
    .MAX_REPORT_BYTES(64)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req        (in_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (out_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_pad_layout(cfg_pad_layout)
  );

  gamepad_report_checker #(
    .MAX_REPORT_BYTES(64)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req        (in_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (out_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_pad_layout(cfg_pad_layout),
    .n_fail        (n_fail),
    .n_pending     (n_pending),
    .n_results     (n_results),
    .n_ok          (n_ok)
  );

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(1, 100) <= idle_pct) begin
      stall_left <= $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= '{report_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_report();
    foreach (report[i]) push_byte(report[i], i == report.size() - 1);
    sent_reports++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (n_pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_layout(input logic value);
    drain();
    cfg_valid <= 1'b1;
    cfg_pad_layout <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    layout_writes++;
  endtask

  task automatic make_report(input logic gen4);
    int         kind;
    int         len;
    int         base_pos;
    int         last_rel;
    int         batt_rel;
    int         min_len;
    logic [7:0] id;
    kind = $urandom_range(0, 99);
    id = $urandom_range(0, 1) ? gdec_pkg::ID_COMMON
                              : (gen4 ? gdec_pkg::ID_GEN4 : gdec_pkg::ID_GEN5);
    base_pos = (id == gdec_pkg::ID_COMMON) ? gdec_pkg::BASE_COMMON
                                           : (gen4 ? gdec_pkg::BASE_GEN4
                                                   : gdec_pkg::BASE_GEN5);
    min_len = gen4 ? gdec_pkg::MIN_LEN_GEN4 : gdec_pkg::MIN_LEN_GEN5;
    last_rel = gen4 ? gdec_pkg::LAST_REL_GEN4 : gdec_pkg::LAST_REL_GEN5;
    batt_rel = gen4 ? gdec_pkg::BATT_REL_GEN4 : gdec_pkg::BATT_REL_GEN5;
    if (kind < 8) begin
      id = rand_byte();
      len = $urandom_range(1, 20);
    end else if (kind < 12) begin
      id = gen4 ? gdec_pkg::ID_GEN5 : gdec_pkg::ID_GEN4;
      len = $urandom_range(min_len, 20);
    end else if (kind < 20) begin
      len = $urandom_range(1, base_pos + last_rel);
    end else if (kind < 72) begin
      len = $urandom_range(base_pos + last_rel + 1, base_pos + last_rel + 12);
    end else if (kind < 90) begin
      len = $urandom_range(base_pos + batt_rel, base_pos + batt_rel + 4);
    end else begin
      len = $urandom_range(60, 80);
    end
    report.delete();
    report.push_back(id);
    for (int i = 1; i < len; i++) report.push_back(rand_byte());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_layout(gdec_pkg::LAYOUT_GEN5);

    report = {gdec_pkg::ID_COMMON};
    send_report();
    report = {gdec_pkg::ID_GEN5, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h5A,
              8'hF7, 8'hF3, 8'h00, 8'h00};
    send_report();
    report = {gdec_pkg::ID_GEN4, 8'h80, 8'h7F, 8'h80, 8'h7F, 8'h00, 8'hFF, 8'hAA,
              8'h55, 8'hFF, 8'h00, 8'h01};
    send_report();

    next_phase = sent_bytes;
    while (sent_bytes < REPORT_BYTES) begin
      calm = (sent_bytes >= REPORT_BYTES - CALM_BYTES);
      if (sent_bytes >= next_phase) begin
        cur_layout = !cur_layout;
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 4;
          default: idle_pct = 12;
        endcase
        write_layout(cur_layout);
        next_phase = sent_bytes + PHASE_BYTES;
      end else if ($urandom_range(0, 9) == 0) begin
        drain();
      end
      if (calm) idle_pct = 0;
      make_report(cur_layout);
      send_report();
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (n_pending != 0);
    repeat (4) @(posedge clk);

    $display("Summary: %0d report bytes in %0d reports across %0d layout writes.",
             sent_bytes, sent_reports, layout_writes);
    $display("Summary: %0d results compared, %0d decoded ok, %0d mismatching.",
             n_results, n_ok, n_fail);
    if (n_fail == 0 && n_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
